// File: rtl/ctac_pkg.sv
`default_nettype none

package ctac_pkg;

  // request kinds
  localparam logic [1:0] KIND_ARM    = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;
  localparam logic [1:0] KIND_POLL   = 2'd3;

  // targets
  localparam logic TGT_DDR = 1'b0;
  localparam logic TGT_BUF = 1'b1;

  // rearm modes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_STOPPED  = 2'd1;
  localparam logic [1:0] MODE_DEFERRED = 2'd2;

  // statuses
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_ARMED = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // sequencer sources
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_BUF  = 2'd1;
  localparam logic [1:0] SEQ_DDR  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DDR_REARM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_REARM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_SOURCE = 2'd3;

  typedef struct packed {
    logic       sync_mode;
    logic       ddr_auto_rearm;
    logic       buf_auto_rearm;
    logic [1:0] seq_source;
  } cfg_t;

  typedef struct packed {
    logic       ddr_arm_flag;
    logic       buf_arm_flag;
    logic       seq_armed;
    logic       ddr_ext;
    logic       buf_ext;
    logic [1:0] ddr_mode;
    logic [1:0] buf_mode;
  } ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       target_sel;
    logic       new_external;
    logic       hw_ddr_armed;
    logic       hw_ddr_busy;
    logic       hw_ddr_iq;
    logic       hw_buf_armed;
    logic       hw_buf_busy;
    logic       hw_buf_iq;
    logic       hw_seq_busy;
    logic [1:0] hw_seq_source;
  } req_t;

  typedef struct packed {
    logic       fire_ddr;
    logic       fire_buf;
    logic       fire_seq;
    logic       fire_external;
    logic       stop_ddr;
    logic       stop_buf;
    logic [1:0] ddr_st;
    logic [1:0] buf_st;
    logic [1:0] seq_st;
    logic       ddr_done;
    logic       buf_done;
    logic       last;
  } res_t;

  typedef struct packed {
    ctl_t ctl;
    logic f_ddr;
    logic f_buf;
    logic f_seq;
    logic f_ext;
  } arm_t;

  function automatic logic may_arm(ctl_t s, cfg_t c, logic self, logic t, logic ext,
                                   logic auto_req);
    logic       ok;
    logic       t_ext;
    logic       t_armed;
    logic       t_auto;
    logic [1:0] t_mode;
    t_ext   = t ? s.buf_ext : s.ddr_ext;
    t_armed = t ? s.buf_arm_flag : s.ddr_arm_flag;
    t_auto  = t ? c.buf_auto_rearm : c.ddr_auto_rearm;
    t_mode  = t ? s.buf_mode : s.ddr_mode;
    ok = (t_ext == ext) && !t_armed && (c.sync_mode || (self == t));
    if (!auto_req) begin
      return ok;
    end
    case (t_mode)
      MODE_NORMAL:   return ok && t_auto;
      MODE_DEFERRED: return ok;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic arm_t arm_request(ctl_t s, cfg_t c, logic t, logic auto_req);
    arm_t r;
    logic ext;
    logic a_ddr;
    logic a_buf;
    logic a_seq;
    logic busy;
    r     = '0;
    r.ctl = s;
    ext   = t ? s.buf_ext : s.ddr_ext;
    a_ddr = may_arm(s, c, t, TGT_DDR, ext, auto_req);
    a_buf = may_arm(s, c, t, TGT_BUF, ext, auto_req);
    a_seq = ((c.seq_source == SEQ_BUF) && a_buf) || ((c.seq_source == SEQ_DDR) && a_ddr);
    busy  = c.sync_mode && (((s.ddr_ext == ext) && s.ddr_arm_flag) ||
                            ((s.buf_ext == ext) && s.buf_arm_flag));
    if (busy) begin
      // partner still capturing: remember the arm for the next rearm
      if (may_arm(s, c, t, t, ext, auto_req)) begin
        if (t) r.ctl.buf_mode = MODE_DEFERRED;
        else   r.ctl.ddr_mode = MODE_DEFERRED;
      end
    end else begin
      if (a_ddr) begin
        r.ctl.ddr_arm_flag = 1'b1;
        r.ctl.ddr_mode     = MODE_NORMAL;
      end
      if (a_buf) begin
        r.ctl.buf_arm_flag = 1'b1;
        r.ctl.buf_mode     = MODE_NORMAL;
      end
      if (a_seq) r.ctl.seq_armed = 1'b1;
      r.f_ddr = a_ddr;
      r.f_buf = a_buf;
      r.f_seq = a_seq;
      r.f_ext = (a_ddr || a_buf) ? ext : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [1:0] status_of(logic armed, logic busy);
    return armed ? ST_ARMED : (busy ? ST_BUSY : ST_READY);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ctac_in_if.sv
`default_nettype none

interface ctac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       target_sel;
  logic       new_external;
  logic       hw_ddr_armed;
  logic       hw_ddr_busy;
  logic       hw_ddr_iq;
  logic       hw_buf_armed;
  logic       hw_buf_busy;
  logic       hw_buf_iq;
  logic       hw_seq_busy;
  logic [1:0] hw_seq_source;

  modport source (
    output valid, kind, target_sel, new_external, hw_ddr_armed, hw_ddr_busy, hw_ddr_iq,
           hw_buf_armed, hw_buf_busy, hw_buf_iq, hw_seq_busy, hw_seq_source,
    input  ready
  );
  modport sink (
    input  valid, kind, target_sel, new_external, hw_ddr_armed, hw_ddr_busy, hw_ddr_iq,
           hw_buf_armed, hw_buf_busy, hw_buf_iq, hw_seq_busy, hw_seq_source,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/ctac_out_if.sv
`default_nettype none

interface ctac_out_if;
  logic       valid;
  logic       ready;
  logic       fire_ddr;
  logic       fire_buf;
  logic       fire_seq;
  logic       fire_external;
  logic       stop_ddr;
  logic       stop_buf;
  logic [1:0] ddr_st;
  logic [1:0] buf_st;
  logic [1:0] seq_st;
  logic       ddr_done;
  logic       buf_done;
  logic       last;

  modport source (
    output valid, fire_ddr, fire_buf, fire_seq, fire_external, stop_ddr, stop_buf,
           ddr_st, buf_st, seq_st, ddr_done, buf_done, last,
    input  ready
  );
  modport sink (
    input  valid, fire_ddr, fire_buf, fire_seq, fire_external, stop_ddr, stop_buf,
           ddr_st, buf_st, seq_st, ddr_done, buf_done, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/capture_trigger_arm_controller_top.sv
// A request taken in is held in the input register, then its results go to the result register;
// a full result register or a pending second poll result holds it in the input register.
// One request per cycle while results drain; a poll that sees both captures complete gives
// two results, and the second waits in its own register behind the first.
// Reset (rst_n low, synchronous): configuration, armed flags, sources, modes and valid
// flags clear; the data registers are not reset.
`default_nettype none

module capture_trigger_arm_controller_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ctac_in_if.sink                              in_ch,
  ctac_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ctac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctac_pkg::CFG_DATA_W-1:0] cfg_data
);

  ctac_pkg::cfg_t cfg_r;
  ctac_pkg::ctl_t ctl_r, ctl_nxt;
  ctac_pkg::req_t req_r;
  ctac_pkg::res_t out_r, sec_r, res0, res1;
  logic           req_v_r, out_v_r, sec_v_r;
  logic           two_res;
  logic           proc;

  ctac_pkg::arm_t arm_a, arm_b;
  ctac_pkg::ctl_t ctl_clr;
  logic [1:0]     ds, bs, ss;
  logic           d_ready, b_ready, s_ready;

  assign proc        = req_v_r && !sec_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !req_v_r || proc;

  always_comb begin
    ds = ctac_pkg::status_of(req_r.hw_ddr_armed,
           (req_r.hw_ddr_busy && !req_r.hw_ddr_iq) ||
           (req_r.hw_seq_busy && (req_r.hw_seq_source == ctac_pkg::SEQ_DDR)));
    bs = ctac_pkg::status_of(req_r.hw_buf_armed,
           (req_r.hw_buf_busy && !req_r.hw_buf_iq) ||
           (req_r.hw_buf_busy && req_r.hw_buf_iq && req_r.hw_seq_busy) ||
           (req_r.hw_seq_busy && (req_r.hw_seq_source == ctac_pkg::SEQ_BUF)));
    ss = ctac_pkg::status_of(
           ((req_r.hw_seq_source == ctac_pkg::SEQ_BUF) && req_r.hw_buf_armed) ||
           ((req_r.hw_seq_source == ctac_pkg::SEQ_DDR) && req_r.hw_ddr_armed),
           req_r.hw_seq_busy);
    d_ready = ctl_r.ddr_arm_flag && (ds == ctac_pkg::ST_READY);
    b_ready = ctl_r.buf_arm_flag && (bs == ctac_pkg::ST_READY);
    s_ready = ctl_r.seq_armed && (ss == ctac_pkg::ST_READY);

    ctl_clr = ctl_r;
    if (d_ready) ctl_clr.ddr_arm_flag = 1'b0;
    if (b_ready) ctl_clr.buf_arm_flag = 1'b0;
    if (s_ready) ctl_clr.seq_armed = 1'b0;

    // DDR rearms first; BUF rearm sees what the DDR rearm left
    arm_a = ctac_pkg::arm_request(ctl_clr, cfg_r, ctac_pkg::TGT_DDR, 1'b1);
    if (!d_ready) arm_a.ctl = ctl_clr;
    arm_b = ctac_pkg::arm_request(arm_a.ctl, cfg_r, ctac_pkg::TGT_BUF, 1'b1);
  end

  always_comb begin
    ctac_pkg::arm_t arm_m;
    arm_m   = ctac_pkg::arm_request(ctl_r, cfg_r, req_r.target_sel, 1'b0);
    ctl_nxt = ctl_r;
    res0    = '0;
    res1    = '0;
    two_res = 1'b0;
    case (req_r.kind)
      ctac_pkg::KIND_ARM: begin
        ctl_nxt            = arm_m.ctl;
        res0.fire_ddr      = arm_m.f_ddr;
        res0.fire_buf      = arm_m.f_buf;
        res0.fire_seq      = arm_m.f_seq;
        res0.fire_external = arm_m.f_ext;
        res0.last          = 1'b1;
      end
      ctac_pkg::KIND_STOP, ctac_pkg::KIND_SELECT: begin
        if (req_r.target_sel) begin
          ctl_nxt.buf_mode     = ctac_pkg::MODE_STOPPED;
          ctl_nxt.buf_arm_flag = 1'b0;
          res0.stop_buf        = 1'b1;
          if (req_r.kind == ctac_pkg::KIND_SELECT) ctl_nxt.buf_ext = req_r.new_external;
        end else begin
          ctl_nxt.ddr_mode     = ctac_pkg::MODE_STOPPED;
          ctl_nxt.ddr_arm_flag = 1'b0;
          res0.stop_ddr        = 1'b1;
          if (req_r.kind == ctac_pkg::KIND_SELECT) ctl_nxt.ddr_ext = req_r.new_external;
        end
        res0.last = 1'b1;
      end
      ctac_pkg::KIND_POLL: begin
        two_res       = d_ready && b_ready;
        res0.ddr_st   = ds;
        res0.buf_st   = bs;
        res0.seq_st   = ss;
        res0.ddr_done = d_ready;
        res0.buf_done = b_ready;
        res1.ddr_st   = ds;
        res1.buf_st   = bs;
        res1.seq_st   = ss;
        res1.last     = 1'b1;
        ctl_nxt       = arm_a.ctl;
        if (d_ready) begin
          res0.fire_ddr      = arm_a.f_ddr;
          res0.fire_buf      = arm_a.f_buf;
          res0.fire_seq      = arm_a.f_seq;
          res0.fire_external = arm_a.f_ext;
        end
        if (b_ready) begin
          ctl_nxt = arm_b.ctl;
          if (two_res) begin
            res1.fire_ddr      = arm_b.f_ddr;
            res1.fire_buf      = arm_b.f_buf;
            res1.fire_seq      = arm_b.f_seq;
            res1.fire_external = arm_b.f_ext;
          end else begin
            res0.fire_ddr      = arm_b.f_ddr;
            res0.fire_buf      = arm_b.f_buf;
            res0.fire_seq      = arm_b.f_seq;
            res0.fire_external = arm_b.f_ext;
          end
        end
        res0.last = !two_res;
      end
      default: begin
        res0.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      ctl_r   <= '0;
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
      sec_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ctac_pkg::CFG_SYNC_MODE:  cfg_r.sync_mode      <= cfg_data[0];
          ctac_pkg::CFG_DDR_REARM:  cfg_r.ddr_auto_rearm <= cfg_data[0];
          ctac_pkg::CFG_BUF_REARM:  cfg_r.buf_auto_rearm <= cfg_data[0];
          ctac_pkg::CFG_SEQ_SOURCE: cfg_r.seq_source     <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        req_v_r <= 1'b1;
      end else if (proc) begin
        req_v_r <= 1'b0;
      end
      if (proc) begin
        ctl_r   <= ctl_nxt;
        out_v_r <= 1'b1;
        sec_v_r <= two_res;
      end else if (out_v_r && out_ch.ready) begin
        out_v_r <= sec_v_r;
        sec_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r.kind          <= in_ch.kind;
      req_r.target_sel    <= in_ch.target_sel;
      req_r.new_external  <= in_ch.new_external;
      req_r.hw_ddr_armed  <= in_ch.hw_ddr_armed;
      req_r.hw_ddr_busy   <= in_ch.hw_ddr_busy;
      req_r.hw_ddr_iq     <= in_ch.hw_ddr_iq;
      req_r.hw_buf_armed  <= in_ch.hw_buf_armed;
      req_r.hw_buf_busy   <= in_ch.hw_buf_busy;
      req_r.hw_buf_iq     <= in_ch.hw_buf_iq;
      req_r.hw_seq_busy   <= in_ch.hw_seq_busy;
      req_r.hw_seq_source <= in_ch.hw_seq_source;
    end
    if (proc) begin
      out_r <= res0;
      sec_r <= res1;
    end else if (out_v_r && out_ch.ready && sec_v_r) begin
      out_r <= sec_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.fire_ddr      = out_r.fire_ddr;
  assign out_ch.fire_buf      = out_r.fire_buf;
  assign out_ch.fire_seq      = out_r.fire_seq;
  assign out_ch.fire_external = out_r.fire_external;
  assign out_ch.stop_ddr      = out_r.stop_ddr;
  assign out_ch.stop_buf      = out_r.stop_buf;
  assign out_ch.ddr_st        = out_r.ddr_st;
  assign out_ch.buf_st        = out_r.buf_st;
  assign out_ch.seq_st        = out_r.seq_st;
  assign out_ch.ddr_done      = out_r.ddr_done;
  assign out_ch.buf_done      = out_r.buf_done;
  assign out_ch.last          = out_r.last;

  // second poll result never waits without a first one ahead of it
  a_sec_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sec_v_r |-> out_v_r)
    else $error("second result pending with empty result register");

  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.last) |-> sec_v_r)
    else $error("result without last flag has no follower");

  a_sec_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    sec_v_r |-> (sec_r.last && !sec_r.ddr_done && !sec_r.buf_done))
    else $error("second poll result malformed");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctl_r.ddr_mode == ctac_pkg::MODE_NORMAL) ||
     (ctl_r.ddr_mode == ctac_pkg::MODE_STOPPED) ||
     (ctl_r.ddr_mode == ctac_pkg::MODE_DEFERRED)) &&
    ((ctl_r.buf_mode == ctac_pkg::MODE_NORMAL) ||
     (ctl_r.buf_mode == ctac_pkg::MODE_STOPPED) ||
     (ctl_r.buf_mode == ctac_pkg::MODE_DEFERRED)))
    else $error("rearm mode out of range");

endmodule

`default_nettype wire
